>>> sv/psd_pkg.sv
// shared widths, limits and region codes for the point to segment distance unit
`default_nettype none
package psd_pkg;

  localparam int COORD_BITS = 32;

  // coordinate differences
  localparam int DW = COORD_BITS + 1;
  // full products and the sums of two squares
  localparam int PW = 2 * DW;
  // divider numerator, denominator and quotient
  localparam int NW = 2 * PW;
  localparam int MW = PW;
  localparam int QW = PW;
  // square root result and its partial remainder
  localparam int RW = QW / 2;
  localparam int SRW = RW + 3;

  localparam int DIST_W = 34;
  localparam logic [RW+DIST_W-1:0] DIST_MAX = {{RW{1'b0}}, {DIST_W{1'b1}}};

  typedef enum logic [1:0] {
    REGION_DEGEN    = 2'd0,
    REGION_START    = 2'd1,
    REGION_END      = 2'd2,
    REGION_INTERIOR = 2'd3
  } region_t;

endpackage
`default_nettype wire

>>> sv/point_segment_distance_unit.sv
// Point to segment distance unit: exact fixed point distance in a deep pipeline
//
// in_ channel: one beat carries a query point and the start and end of a segment,
// all signed with the same fraction scale. out_ channel: one beat carries the
// truncated distance (same scale, unsigned) and a region code telling whether the
// segment was degenerate, the start or end was nearest, or an interior point was.
// A beat is taken on a rising edge with valid high and stall low.
// One beat is accepted every cycle while the pipeline is not stalled. Six
// arithmetic stages form the products and the numerator, the restoring
// divider spends one stage per quotient bit (QW) and the square root one stage
// per result bit (RW), followed by the output register.
// When the receiver stalls a waiting output beat, the whole pipeline holds and
// in_stall is raised in the same cycle, so nothing is dropped or repeated.
// Reset (synchronous, rst_n low) clears every valid bit; the block takes beats
// as soon as reset is released.
`default_nettype none
module point_segment_distance_unit
  import psd_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] in_point_x,
  input  wire logic signed [COORD_BITS-1:0] in_point_y,
  input  wire logic signed [COORD_BITS-1:0] in_seg_start_x,
  input  wire logic signed [COORD_BITS-1:0] in_seg_start_y,
  input  wire logic signed [COORD_BITS-1:0] in_seg_end_x,
  input  wire logic signed [COORD_BITS-1:0] in_seg_end_y,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [DIST_W-1:0]                 out_distance,
  output logic [1:0]                        out_region
);

  localparam int L = DW;

  logic en;

  // stage 1: differences
  logic                 v1_r;
  logic signed [DW-1:0] rx_r, ry_r, vx_r, vy_r, wx_r, wy_r;
  logic                 deg1_r;

  // stage 2: products
  logic                 v2_r;
  logic signed [PW-1:0] rxvx_r, ryvy_r, rxrx_r, ryry_r, vxry_r, vyrx_r;
  logic signed [PW-1:0] vxvx_r, vyvy_r, wxwx_r, wywy_r;
  logic                 deg2_r;

  // stage 3: dot products, cross product, squared lengths
  logic                 v3_r;
  logic signed [PW:0]   d1_r, c_r;
  logic [PW-1:0]        d2_r, sv_r, se_r;
  logic                 deg3_r;

  // stage 4: region decision
  logic                 v4_r;
  region_t              reg4_r;
  logic [PW-1:0]        cabs_r, d2_4_r, spt4_r;

  // stage 5: partial products of the squared cross product
  logic                 v5_r;
  region_t              reg5_r;
  logic [2*L-1:0]       aa_r, ab_r, bb_r;
  logic [PW-1:0]        d2_5_r, spt5_r;

  // divider and square root stages
  logic                 dv_r   [0:QW];
  region_t              dreg_r [0:QW];
  logic [MW-1:0]        drem_r [0:QW];
  logic [MW-1:0]        dm_r   [0:QW];
  logic [QW-1:0]        dx_r   [0:QW];

  logic                 sv_vld_r [1:RW];
  region_t              sreg_r   [1:RW];
  logic [QW-1:0]        sx_r     [1:RW];
  logic [SRW-1:0]       srem_r   [1:RW];
  logic [RW-1:0]        sroot_r  [1:RW];

  logic                 out_valid_r;
  logic [DIST_W-1:0]    out_distance_r;
  region_t              out_region_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // ---------------- stage 1
  logic signed [DW-1:0] px_e, py_e, sx_e, sy_e, ex_e, ey_e;
  assign px_e = DW'(in_point_x);
  assign py_e = DW'(in_point_y);
  assign sx_e = DW'(in_seg_start_x);
  assign sy_e = DW'(in_seg_start_y);
  assign ex_e = DW'(in_seg_end_x);
  assign ey_e = DW'(in_seg_end_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r   <= ex_e - sx_e;
      ry_r   <= ey_e - sy_e;
      vx_r   <= px_e - sx_e;
      vy_r   <= py_e - sy_e;
      wx_r   <= px_e - ex_e;
      wy_r   <= py_e - ey_e;
      deg1_r <= (in_seg_start_x == in_seg_end_x) && (in_seg_start_y == in_seg_end_y);
    end
  end

  // ---------------- stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rxvx_r <= rx_r * vx_r;
      ryvy_r <= ry_r * vy_r;
      rxrx_r <= rx_r * rx_r;
      ryry_r <= ry_r * ry_r;
      vxry_r <= vx_r * ry_r;
      vyrx_r <= vy_r * rx_r;
      vxvx_r <= vx_r * vx_r;
      vyvy_r <= vy_r * vy_r;
      wxwx_r <= wx_r * wx_r;
      wywy_r <= wy_r * wy_r;
      deg2_r <= deg1_r;
    end
  end

  // ---------------- stage 3
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r   <= $signed({rxvx_r[PW-1], rxvx_r}) + $signed({ryvy_r[PW-1], ryvy_r});
      c_r    <= $signed({vxry_r[PW-1], vxry_r}) - $signed({vyrx_r[PW-1], vyrx_r});
      d2_r   <= rxrx_r[PW-1:0] + ryry_r[PW-1:0];
      sv_r   <= vxvx_r[PW-1:0] + vyvy_r[PW-1:0];
      se_r   <= wxwx_r[PW-1:0] + wywy_r[PW-1:0];
      deg3_r <= deg2_r;
    end
  end

  // ---------------- stage 4
  region_t            reg4_nxt;
  logic [PW-1:0]      spt4_nxt;
  logic signed [PW:0] cneg;

  assign cneg = -c_r;

  always_comb begin
    if (deg3_r) begin
      reg4_nxt = REGION_DEGEN;
      spt4_nxt = sv_r;
    end else if (d1_r[PW] || (d1_r == '0)) begin
      reg4_nxt = REGION_START;
      spt4_nxt = sv_r;
    end else if ($signed(d1_r) >= $signed({1'b0, d2_r})) begin
      reg4_nxt = REGION_END;
      spt4_nxt = se_r;
    end else begin
      reg4_nxt = REGION_INTERIOR;
      spt4_nxt = sv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      reg4_r <= reg4_nxt;
      spt4_r <= spt4_nxt;
      d2_4_r <= d2_r;
      cabs_r <= c_r[PW] ? cneg[PW-1:0] : c_r[PW-1:0];
    end
  end

  // ---------------- stage 5: |c| squared as three half-width products
  logic [L-1:0] ca, cb;
  assign ca = cabs_r[PW-1:L];
  assign cb = cabs_r[L-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aa_r   <= ca * ca;
      ab_r   <= ca * cb;
      bb_r   <= cb * cb;
      reg5_r <= reg4_r;
      d2_5_r <= d2_4_r;
      spt5_r <= spt4_r;
    end
  end

  // ---------------- stage 6: numerator and denominator for the divider
  logic [NW-1:0] t_aa, t_ab, t_bb, num_nxt;
  logic [MW-1:0] den_nxt;

  assign t_aa = {aa_r, {PW{1'b0}}};
  assign t_ab = {{(L-1){1'b0}}, ab_r, {(L+1){1'b0}}};
  assign t_bb = {{(NW-PW){1'b0}}, bb_r};

  always_comb begin
    if (reg5_r == REGION_INTERIOR) begin
      num_nxt = t_aa + t_ab + t_bb;
      den_nxt = d2_5_r;
    end else begin
      // point distance: divide by one, the root does the rest
      num_nxt = {{(NW-QW){1'b0}}, spt5_r};
      den_nxt = MW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dreg_r[0] <= reg5_r;
      drem_r[0] <= num_nxt[NW-1:QW];
      dx_r[0]   <= num_nxt[QW-1:0];
      dm_r[0]   <= den_nxt;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage
  // quotient bits replace numerator bits in dx as they are shifted out
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [MW:0] trial;
    logic [MW:0] diff;
    logic        ge;
    logic [MW-1:0] rem_nxt;

    assign trial   = {drem_r[k], dx_r[k][QW-1]};
    assign diff    = trial - {1'b0, dm_r[k]};
    assign ge      = trial >= {1'b0, dm_r[k]};
    assign rem_nxt = ge ? diff[MW-1:0] : trial[MW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dreg_r[k+1] <= dreg_r[k];
        drem_r[k+1] <= rem_nxt;
        dx_r[k+1]   <= {dx_r[k][QW-2:0], ge};
        dm_r[k+1]   <= dm_r[k];
      end
    end
  end

  // ---------------- square root, one result bit per stage
  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    logic           v_cur;
    region_t        reg_cur;
    logic [QW-1:0]  x_cur;
    logic [SRW-1:0] rem_cur;
    logic [RW-1:0]  root_cur;
    logic [SRW-1:0] acc;
    logic [SRW-1:0] trial;
    logic           ge;

    if (j == 0) begin : g_first
      assign v_cur    = dv_r[QW];
      assign reg_cur  = dreg_r[QW];
      assign x_cur    = dx_r[QW];
      assign rem_cur  = '0;
      assign root_cur = '0;
    end else begin : g_next
      assign v_cur    = sv_vld_r[j];
      assign reg_cur  = sreg_r[j];
      assign x_cur    = sx_r[j];
      assign rem_cur  = srem_r[j];
      assign root_cur = sroot_r[j];
    end

    assign acc   = {rem_cur[SRW-3:0], x_cur[QW-1:QW-2]};
    assign trial = {1'b0, root_cur, 2'b01};
    assign ge    = acc >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_vld_r[j+1] <= 1'b0;
      end else if (en) begin
        sv_vld_r[j+1] <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sreg_r[j+1]  <= reg_cur;
        sx_r[j+1]    <= {x_cur[QW-3:0], 2'b00};
        srem_r[j+1]  <= ge ? (acc - trial) : acc;
        sroot_r[j+1] <= {root_cur[RW-2:0], ge};
      end
    end
  end

  // ---------------- output register
  logic [RW+DIST_W-1:0] root_ext;
  logic [DIST_W-1:0]    dist_nxt;

  assign root_ext = {{DIST_W{1'b0}}, sroot_r[RW]};
  assign dist_nxt = (root_ext > DIST_MAX) ? {DIST_W{1'b1}} : root_ext[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sv_vld_r[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_distance_r <= dist_nxt;
      out_region_r   <= sreg_r[RW];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_region   = out_region_r;

  // ---------------- checks
  a_stall_from_out : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid_r && out_stall))
    else $error("input stall does not follow the held output beat");

  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted beat did not enter the first stage");

  a_div_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[0] |-> (dm_r[0] != '0))
    else $error("divider fed a zero denominator");

  a_div_rem : assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[QW] |-> (drem_r[QW] < dm_r[QW]))
    else $error("divider remainder not below denominator");

endmodule
`default_nettype wire

>>> tb/tb_point_segment_distance_unit.sv
// self-checking testbench for the point to segment distance unit
`timescale 1ns / 100ps
`default_nettype none
module tb_point_segment_distance_unit
  import psd_pkg::*;
();

  localparam int LIMIT = 400000;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [255:0] wide_t;

  typedef struct {
    logic [DIST_W-1:0] distance;
    region_t           region;
  } seg_dist_t;

  // floor of sqrt(n / m), found one bit at a time
  function automatic logic [DIST_W-1:0] floor_root(wide_t n, wide_t m);
    logic [DIST_W-1:0] t;
    logic [DIST_W-1:0] cand;
    wide_t prod;
    t = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      cand = t | (DIST_W'(1) << b);
      prod = wide_t'(cand) * wide_t'(cand) * m;
      if (prod <= n) t = cand;
    end
    return t;
  endfunction

  function automatic logic [DIST_W-1:0] pt_dist(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    logic signed [255:0] dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return floor_root(dx * dx + dy * dy, wide_t'(1));
  endfunction

  function automatic seg_dist_t predict_distance(coord_t px, coord_t py, coord_t sx,
                                                 coord_t sy, coord_t ex, coord_t ey);
    logic signed [255:0] rx, ry, vx, vy, d1, d2, c;
    seg_dist_t res;
    rx = longint'(ex) - longint'(sx);
    ry = longint'(ey) - longint'(sy);
    vx = longint'(px) - longint'(sx);
    vy = longint'(py) - longint'(sy);
    d1 = rx * vx + ry * vy;
    d2 = rx * rx + ry * ry;
    if (sx == ex && sy == ey) begin
      res.distance = pt_dist(px, py, sx, sy);
      res.region = REGION_DEGEN;
    end else if (d1 <= 0) begin
      res.distance = pt_dist(px, py, sx, sy);
      res.region = REGION_START;
    end else if (d1 >= d2) begin
      res.distance = pt_dist(px, py, ex, ey);
      res.region = REGION_END;
    end else begin
      c = vx * ry - vy * rx;
      res.distance = floor_root(c * c, d2);
      res.region = REGION_INTERIOR;
    end
    return res;
  endfunction

  class distance_scoreboard;
    seg_dist_t pending[$];
    int errors;
    int taken;
    int region_seen[4];

    function void note_item(coord_t px, coord_t py, coord_t sx, coord_t sy,
                            coord_t ex, coord_t ey);
      seg_dist_t r;
      r = predict_distance(px, py, sx, sy, ex, ey);
      pending.push_back(r);
      taken++;
      region_seen[r.region]++;
    endfunction

    function void check_beat(logic [DIST_W-1:0] distance, logic [1:0] region);
      seg_dist_t want;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: distance %0d region %0d", distance, region);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (distance !== want.distance) begin
        $error("distance: expected %0d, got %0d", want.distance, distance);
        errors++;
      end
      if (region !== want.region) begin
        $error("region: expected %0d, got %0d", want.region, region);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  coord_t in_point_x, in_point_y, in_seg_start_x, in_seg_start_y, in_seg_end_x, in_seg_end_y;
  logic [DIST_W-1:0] out_distance;
  logic [1:0] out_region;

  distance_scoreboard sb = new();
  bit calm = 1'b0;
  int stall_left = 0;
  int cycles = 0;

  point_segment_distance_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_seg_start_x(in_seg_start_x), .in_seg_start_y(in_seg_start_y),
    .in_seg_end_x(in_seg_end_x), .in_seg_end_y(in_seg_end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distance(out_distance), .out_region(out_region)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // beat monitor, sees pre-edge values
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_item(in_point_x, in_point_y, in_seg_start_x, in_seg_start_y,
                   in_seg_end_x, in_seg_end_y);
    if (rst_n && out_valid && !out_stall)
      sb.check_beat(out_distance, out_region);
  end

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_beat(coord_t px, coord_t py, coord_t sx, coord_t sy,
                           coord_t ex, coord_t ey);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_point_x <= px;
    in_point_y <= py;
    in_seg_start_x <= sx;
    in_seg_start_y <= sy;
    in_seg_end_x <= ex;
    in_seg_end_y <= ey;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(int mode);
    coord_t sx, sy, ex, ey, px, py;
    int span;
    case (mode)
      0: begin
        // full range, every bit toggles
        send_beat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      1: begin
        // degenerate segment
        sx = $urandom;
        sy = $urandom;
        send_beat($urandom, $urandom, sx, sy, sx, sy);
      end
      default: begin
        // point near a moderate segment, mostly interior
        span = 1 << $urandom_range(2, 28);
        sx = $urandom_range(0, 2 * span) - span;
        sy = $urandom_range(0, 2 * span) - span;
        ex = $urandom_range(0, 2 * span) - span;
        ey = $urandom_range(0, 2 * span) - span;
        px = (sx + ex) / 2 + $signed($urandom_range(0, span)) - span / 2;
        py = (sy + ey) / 2 + $signed($urandom_range(0, span)) - span / 2;
        send_beat(px, py, sx, sy, ex, ey);
      end
    endcase
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  localparam coord_t CMAX = 32'sh7fffffff;
  localparam coord_t CMIN = 32'sh80000000;

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_point_x <= '0;
    in_point_y <= '0;
    in_seg_start_x <= '0;
    in_seg_start_y <= '0;
    in_seg_end_x <= '0;
    in_seg_end_y <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    send_beat(0, 0, 0, 0, 0, 0);
    send_beat(CMAX, CMAX, CMIN, CMIN, CMIN, CMIN);
    send_beat(CMIN, CMAX, CMAX, CMIN, CMAX, CMIN);
    send_beat(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN);
    send_beat(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX);
    send_beat(CMIN, CMAX, CMIN, CMIN, CMAX, CMAX);
    send_beat(CMAX, CMIN, CMIN, CMIN, CMAX, CMAX);
    send_beat(-32'sd5, 32'sd3, 0, 0, 32'sd10, 0);
    send_beat(0, 32'sd7, 0, 0, 32'sd10, 0);        // projection exactly on start
    send_beat(32'sd10, -32'sd4, 0, 0, 32'sd10, 0); // projection exactly on end
    send_beat(32'sd15, 32'sd2, 0, 0, 32'sd10, 0);
    send_beat(32'sd3, 32'sd4, 0, 0, 32'sd10, 0);
    send_beat(32'sd5, 0, 0, 0, 32'sd10, 0);        // point on the segment
    send_beat(32'sd65536, 32'sd65536, 0, 0, 32'sd131072, 32'sd1);
    send_beat(CMAX, 0, CMIN, 0, CMAX, 32'sd1);
    send_beat(1, -1, -1, 1, 1, 1);
    in_valid <= 1'b0;
    wait_drained();

    for (int i = 0; i < 700; i++) begin
      if (i == 550) calm = 1'b1;
      send_random($urandom_range(0, 5) == 0 ? 1 : ($urandom_range(0, 2) == 0 ? 0 : 2));
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (250) @(posedge clk);

    $display("covered %0d beats: degenerate %0d, start %0d, end %0d, interior %0d",
             sb.taken, sb.region_seen[0], sb.region_seen[1], sb.region_seen[2],
             sb.region_seen[3]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
sv/psd_pkg.sv
sv/point_segment_distance_unit.sv
tb/tb_point_segment_distance_unit.sv
